[sv/dmr_pkg.sv]
// Shared types and constants of the diamond mask rasterizer.
`default_nettype none

package dmr_pkg;

  // Field widths
  localparam int unsigned CoordW  = 12;
  localparam int unsigned OwW     = 8;
  localparam int unsigned ScrW    = 13;
  localparam int unsigned CfgW    = 13;
  localparam int unsigned IndexW  = 24;
  localparam int unsigned OffsetW = 26;

  // Signed geometry terms and edge dot products
  localparam int unsigned GeoW = CoordW + 2;
  localparam int unsigned ProdW = 2 * GeoW;
  localparam int unsigned DotW = ProdW + 1;

  // Edges of the diamond
  localparam int unsigned NumEdges = 4;
  localparam int unsigned EdgeTl = 0;
  localparam int unsigned EdgeBl = 1;
  localparam int unsigned EdgeTr = 2;
  localparam int unsigned EdgeBr = 3;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_LENS_WIDTH    = 2'd0,
    CFG_LENS_HEIGHT   = 2'd1,
    CFG_OUTLINE_WIDTH = 2'd2,
    CFG_SCREEN_WIDTH  = 2'd3
  } cfg_idx_e;

  // Configuration-derived geometry handed to the datapath
  typedef struct packed {
    logic [CoordW-1:0]      lens_width;
    logic [ScrW-1:0]        screen_width;
    logic [OwW-1:0]         ow;
    logic [CoordW-2:0]      cy;
    logic signed [GeoW-1:0] rx;
    logic signed [GeoW-1:0] n1x;
    logic signed [GeoW-1:0] n1y;
    logic signed [GeoW-1:0] n2x;
    logic signed [GeoW-1:0] n2y;
    logic [NumEdges-1:0]    u_zero;
    logic [NumEdges-1:0]    u_neg;
  } dmr_geom_t;

endpackage

`default_nettype wire

[sv/diamond_mask_rasterizer.sv]
// Top level of the diamond mask rasterizer: handshake, pipeline registers, datapath.
`default_nettype none

// Diamond mask rasterizer. Each input item is one pixel (pixel_x, pixel_y) of a
// lens bounding box of lens_width by lens_height pixels; the matching result item
// says whether the pixel lies inside or on a diamond whose corners are the box side
// midpoints pulled in by outline_width, and carries the pixel's lens mask index
// (pixel_y*lens_width+pixel_x, 24 bits) and the byte offset of the screen pixel
// ((pixel_y*screen_width+pixel_x)*4, 26 bits), both wrapping. The block takes one
// item per clock while the output is not stalled, and returns it in order:
// the pixel is held in an input register, one pass of six 14-bit signed multipliers
// for the edge functions and two address multipliers, with their adds and sign
// compares, produces the result, and a result register drives the output. A
// stalled result holds; the input register keeps taking items until it holds one
// that cannot advance. Configuration writes are always ready and take effect on
// items accepted from the next cycle on; write them only while no item is in
// flight. Register indexes: 0 lens_width, 1 lens_height, 2 outline_width,
// 3 screen_width. After reset the sizes are 64 by 64, the inset 0 and the screen
// row 640 pixels.
module diamond_mask_rasterizer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [dmr_pkg::CfgW-1:0]    cfg_data_i,
  // Pixel input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [dmr_pkg::CoordW-1:0]  pixel_x_i,
  input  logic [dmr_pkg::CoordW-1:0]  pixel_y_i,
  // Result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        inside_res_o,
  output logic [dmr_pkg::IndexW-1:0]  lens_index_o,
  output logic [dmr_pkg::OffsetW-1:0] source_offset_o
);
  import dmr_pkg::*;

  dmr_geom_t geom;

  // Input register
  logic              s1_valid_q, s1_valid_d;
  logic [CoordW-1:0] x_q, y_q;
  logic              s1_load;

  // Result register
  logic               s2_valid_q, s2_valid_d;
  logic               inside_q;
  logic [IndexW-1:0]  index_q;
  logic [OffsetW-1:0] offset_q;
  logic               s2_load;

  logic               inside_d;
  logic [IndexW-1:0]  index_d;
  logic [OffsetW-1:0] offset_d;

  // Configuration is always accepted
  assign cfg_ready_o = 1'b1;

  dmr_geom u_geom (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .geom_o     (geom)
  );

  dmr_datapath u_datapath (
    .pixel_x_i      (x_q),
    .pixel_y_i      (y_q),
    .geom_i         (geom),
    .inside_o       (inside_d),
    .lens_index_o   (index_d),
    .source_offset_o(offset_d)
  );

  // Advance the result register whenever it is empty or being drained
  assign s2_load    = !s2_valid_q || !out_stall_i;
  // Hold the input register only while its item cannot move forward
  assign in_stall_o = s1_valid_q && !s2_load;
  assign s1_load    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s2_load || !s1_valid_q) begin
      s1_valid_d = in_valid_i;
    end
    s2_valid_d = s2_valid_q;
    if (s2_load) begin
      s2_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      x_q <= pixel_x_i;
      y_q <= pixel_y_i;
    end
    if (s2_load && s1_valid_q) begin
      inside_q <= inside_d;
      index_q  <= index_d;
      offset_q <= offset_d;
    end
  end

  assign out_valid_o     = s2_valid_q;
  assign inside_res_o    = inside_q;
  assign lens_index_o    = index_q;
  assign source_offset_o = offset_q;

endmodule

`default_nettype wire

[sv/dmr_geom.sv]
// Configuration registers and registered diamond geometry.
`default_nettype none

module dmr_geom (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [dmr_pkg::CfgW-1:0]    cfg_data_i,
  output dmr_pkg::dmr_geom_t          geom_o
);
  import dmr_pkg::*;

  logic [CoordW-1:0] lens_w_q, lens_h_q;
  logic [OwW-1:0]    ow_q;
  logic [ScrW-1:0]   scr_w_q;

  logic signed [GeoW-1:0] w_s, h_s, ow_s, cx_s, cy_s;
  logic signed [GeoW-1:0] rx_s, n1x_s, n1y_s, n2x_s, n2y_s, crx_s;
  dmr_geom_t geom_d, geom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lens_w_q <= CoordW'(64);
      lens_h_q <= CoordW'(64);
      ow_q     <= '0;
      scr_w_q  <= ScrW'(640);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LENS_WIDTH:    lens_w_q <= cfg_data_i[CoordW-1:0];
        CFG_LENS_HEIGHT:   lens_h_q <= cfg_data_i[CoordW-1:0];
        CFG_OUTLINE_WIDTH: ow_q     <= cfg_data_i[OwW-1:0];
        CFG_SCREEN_WIDTH:  scr_w_q  <= cfg_data_i[ScrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_s  = $signed({2'b00, lens_w_q});
    h_s  = $signed({2'b00, lens_h_q});
    ow_s = $signed({{(GeoW-OwW){1'b0}}, ow_q});
    cx_s = $signed({3'b000, lens_w_q[CoordW-1:1]});
    cy_s = $signed({3'b000, lens_h_q[CoordW-1:1]});

    rx_s  = w_s - GeoW'(1) - ow_s;
    n1x_s = ow_s - cy_s;
    n1y_s = ow_s - cx_s;
    n2x_s = cy_s - h_s + GeoW'(1) + ow_s;
    n2y_s = cx_s - ow_s;
    crx_s = cx_s - rx_s;

    geom_d.lens_width   = lens_w_q;
    geom_d.screen_width = scr_w_q;
    geom_d.ow           = ow_q;
    geom_d.cy           = lens_h_q[CoordW-1:1];
    geom_d.rx           = rx_s;
    geom_d.n1x          = n1x_s;
    geom_d.n1y          = n1y_s;
    geom_d.n2x          = n2x_s;
    geom_d.n2y          = n2y_s;

    // Centre-point sign per edge: product of two factor signs
    geom_d.u_zero[EdgeTl] = (n2y_s == '0) || (n2x_s == '0);
    geom_d.u_neg[EdgeTl]  = n2y_s[GeoW-1] ^ n2x_s[GeoW-1];
    geom_d.u_zero[EdgeBl] = (n2y_s == '0) || (n1x_s == '0);
    geom_d.u_neg[EdgeBl]  = n2y_s[GeoW-1] ^ n1x_s[GeoW-1];
    geom_d.u_zero[EdgeTr] = (crx_s == '0) || (n1x_s == '0);
    geom_d.u_neg[EdgeTr]  = crx_s[GeoW-1] ^ n1x_s[GeoW-1];
    geom_d.u_zero[EdgeBr] = (crx_s == '0) || (n2x_s == '0);
    geom_d.u_neg[EdgeBr]  = crx_s[GeoW-1] ^ n2x_s[GeoW-1];
  end

  always_ff @(posedge clk_i) begin
    geom_q <= geom_d;
  end

  assign geom_o = geom_q;

endmodule

`default_nettype wire

[sv/dmr_datapath.sv]
// Edge-function inside test and address arithmetic for one pixel.
`default_nettype none

module dmr_datapath (
  input  logic [dmr_pkg::CoordW-1:0]  pixel_x_i,
  input  logic [dmr_pkg::CoordW-1:0]  pixel_y_i,
  input  dmr_pkg::dmr_geom_t          geom_i,
  output logic                        inside_o,
  output logic [dmr_pkg::IndexW-1:0]  lens_index_o,
  output logic [dmr_pkg::OffsetW-1:0] source_offset_o
);
  import dmr_pkg::*;

  logic signed [GeoW-1:0]  dxl, dxr, dy;
  logic signed [ProdW-1:0] p_l2x, p_l1x, p_r1x, p_r2x, p_y1y, p_y2y;
  logic signed [DotW-1:0]  v [NumEdges];
  logic [NumEdges-1:0]     ok;
  logic [IndexW-1:0]       lens_prod;
  logic [IndexW-1:0]       scr_prod;
  logic [IndexW-1:0]       scr_pix;

  always_comb begin
    dxl = $signed({2'b00, pixel_x_i}) - $signed({{(GeoW-OwW){1'b0}}, geom_i.ow});
    dxr = $signed({2'b00, pixel_x_i}) - geom_i.rx;
    dy  = $signed({2'b00, pixel_y_i}) - $signed({3'b000, geom_i.cy});

    p_l2x = dxl * geom_i.n2x;
    p_l1x = dxl * geom_i.n1x;
    p_r1x = dxr * geom_i.n1x;
    p_r2x = dxr * geom_i.n2x;
    p_y1y = dy * geom_i.n1y;
    p_y2y = dy * geom_i.n2y;

    v[EdgeTl] = DotW'(p_l2x) + DotW'(p_y2y);
    v[EdgeBl] = DotW'(p_l1x) + DotW'(p_y1y);
    v[EdgeTr] = DotW'(p_r1x) + DotW'(p_y1y);
    v[EdgeBr] = DotW'(p_r2x) + DotW'(p_y2y);

    // Pass an edge when either sign is zero or both signs agree
    for (int e = 0; e < NumEdges; e++) begin
      ok[e] = geom_i.u_zero[e] || (v[e] == '0) || (v[e][DotW-1] == geom_i.u_neg[e]);
    end
    inside_o = &ok;

    lens_prod    = pixel_y_i * geom_i.lens_width;
    lens_index_o = lens_prod + IndexW'(pixel_x_i);

    scr_prod = pixel_y_i * geom_i.screen_width;
    scr_pix  = scr_prod + IndexW'(pixel_x_i);
    source_offset_o = {scr_pix, 2'b00};
  end

endmodule

`default_nettype wire

[sv/dmr_checker.sv]
// Port-level checker for the diamond mask rasterizer and its bind.
`default_nettype none

module dmr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        inside_res_o,
  input logic [dmr_pkg::IndexW-1:0]  lens_index_o,
  input logic [dmr_pkg::OffsetW-1:0] source_offset_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(lens_index_o) && $stable(source_offset_o)
      && $stable(inside_res_o))
    else $error("result payload changed while stalled");

  // Input stalls only when a full output is stalled downstream
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // An accepted item passes the input and result registers to the output when not stalled
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted item did not reach the output");

  // Byte offsets are whole pixels
  a_offset_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> source_offset_o[1:0] == 2'b00)
    else $error("source offset not pixel aligned");

endmodule

bind diamond_mask_rasterizer dmr_checker u_dmr_checker (.*);

`default_nettype wire

[sim/tb_diamond_mask_rasterizer.sv]
// Self-checking testbench of the diamond mask rasterizer: pixel stream against a local predictor.
`default_nettype none

module tb_diamond_mask_rasterizer;
  timeunit 1ns;
  timeprecision 1ps;

  import dmr_pkg::*;

  // One pixel offered to the block
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } pixel_t;

  // What the block must return for one pixel
  typedef struct packed {
    logic               in_diamond;
    logic [IndexW-1:0]  lens_index;
    logic [OffsetW-1:0] source_offset;
  } mask_entry_t;

  // Clock, reset and block ports; every input starts at a known value
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  cfg_idx_e         cfg_index = CFG_LENS_WIDTH;
  logic [CfgW-1:0]  cfg_data = '0;

  logic              pix_valid = 1'b0;
  logic              pix_stall;
  logic [CoordW-1:0] pix_x = '0;
  logic [CoordW-1:0] pix_y = '0;

  logic               res_valid;
  logic               res_stall = 1'b0;
  logic               res_inside;
  logic [IndexW-1:0]  res_index;
  logic [OffsetW-1:0] res_offset;

  // Local copy of the block's registers, as the predictor sees them
  logic [CoordW-1:0] lens_w_cur = 12'd64;
  logic [CoordW-1:0] lens_h_cur = 12'd64;
  logic [OwW-1:0]    inset_cur = '0;
  logic [ScrW-1:0]   screen_w_cur = 13'd640;

  // Pixels waiting to be offered, and predicted mask entries waiting for the block
  pixel_t      pixel_q[$];
  mask_entry_t mask_q[$];

  // Handshake bookkeeping and statistics
  logic        pix_took = 1'b0;
  int unsigned n_pixels = 0;
  int unsigned n_inside = 0;
  int unsigned n_results = 0;
  int unsigned n_settings = 0;
  int unsigned n_errors = 0;

  // Sender burst shaping, receiver stall shaping
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  int unsigned next_hold = 60;
  int unsigned mode_left = 0;
  int unsigned stall_mode = 0;
  int unsigned cyc = 0;

  diamond_mask_rasterizer i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (pix_valid),
    .in_stall_o      (pix_stall),
    .pixel_x_i       (pix_x),
    .pixel_y_i       (pix_y),
    .out_valid_o     (res_valid),
    .out_stall_i     (res_stall),
    .inside_res_o    (res_inside),
    .lens_index_o    (res_index),
    .source_offset_o (res_offset)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Print one line per mismatch and count it; the run carries on
  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    n_errors++;
  endtask

  function automatic int sign_of(longint a);
    return (a > 0) ? 1 : ((a < 0) ? -1 : 0);
  endfunction

  // Edge-function test against the diamond, plus the two address outputs.
  // Signs of pixel and centre must agree per edge; a zero on either side passes.
  function automatic mask_entry_t rasterize_pixel(logic [CoordW-1:0] px,
                                                  logic [CoordW-1:0] py);
    longint x, y, w, h, ow, sw;
    longint cx, cy, lx, rx, ty, by;
    longint n1x, n1y, n2x, n2y;
    longint u_tl, u_bl, u_tr, u_br;
    longint v_tl, v_bl, v_tr, v_br;
    longint lin, scr;
    mask_entry_t r;
    x  = px;
    y  = py;
    w  = lens_w_cur;
    h  = lens_h_cur;
    ow = inset_cur;
    sw = screen_w_cur;
    // Vertices: left (lx, cy), right (rx, cy), bottom (cx, by), top (cx, ty)
    cx = w / 2;
    cy = h / 2;
    lx = ow;
    rx = w - 1 - ow;
    ty = h - 1 - ow;
    by = ow;
    // n1 serves bottom-left and top-right, n2 serves top-left and bottom-right
    n1x = -(cy - by);
    n1y = lx - cx;
    n2x = -(ty - cy);
    n2y = cx - lx;
    u_tl = (cx - lx) * n2x;
    u_bl = (cx - lx) * n1x;
    u_tr = (cx - rx) * n1x;
    u_br = (cx - rx) * n2x;
    v_tl = (x - lx) * n2x + (y - cy) * n2y;
    v_bl = (x - lx) * n1x + (y - cy) * n1y;
    v_tr = (x - rx) * n1x + (y - cy) * n1y;
    v_br = (x - rx) * n2x + (y - cy) * n2y;
    r.in_diamond = (sign_of(v_tl) * sign_of(u_tl) >= 0) &&
                   (sign_of(v_bl) * sign_of(u_bl) >= 0) &&
                   (sign_of(v_tr) * sign_of(u_tr) >= 0) &&
                   (sign_of(v_br) * sign_of(u_br) >= 0);
    // Both addresses wrap to their field widths
    lin = y * w + x;
    scr = (y * sw + x) * 4;
    r.lens_index    = lin[IndexW-1:0];
    r.source_offset = scr[OffsetW-1:0];
    return r;
  endfunction

  // Pixel sender: bursts of random length separated by random gaps.
  // A new pixel goes out only when the bus is empty or the last one was taken,
  // so a stalled pixel holds steady.
  always @(negedge clk) begin : pixel_sender
    pixel_t nxt;
    if (!rst_n) begin
      pix_valid <= 1'b0;
    end else if (!pix_valid || pix_took) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        // A third of the bursts follow the previous one back to back
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (gap_left > 0) begin
        gap_left--;
        pix_valid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        nxt = pixel_q.pop_front();
        pix_x <= nxt.x;
        pix_y <= nxt.y;
        pix_valid <= 1'b1;
        burst_left--;
      end else begin
        pix_valid <= 1'b0;
      end
    end
  end

  // Result receiver stall. It switches between a few stall patterns at random
  // intervals, and at set points in the pixel count holds off for a long
  // stretch so the pipeline fills and the block must stall its input.
  always @(negedge clk) begin : result_staller
    cyc++;
    if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else if (rst_n && next_hold < 800 && n_pixels >= next_hold) begin
      hold_left = 300;
      next_hold += 350;
      res_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(16, 80);
        stall_mode = $urandom_range(0, 3);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: res_stall <= 1'b0;
        1: res_stall <= ($urandom_range(0, 3) == 0);
        2: res_stall <= ($urandom_range(0, 3) != 0);
        default: res_stall <= ((cyc % 5) < 2);
      endcase
    end
  end

  // Monitor: predict each accepted pixel, check each accepted result in order
  always @(posedge clk) begin : mask_monitor
    mask_entry_t want;
    if (!rst_n) begin
      pix_took <= 1'b0;
    end else begin
      pix_took <= pix_valid && !pix_stall;
      if (pix_valid && !pix_stall) begin
        want = rasterize_pixel(pix_x, pix_y);
        mask_q.push_back(want);
        n_pixels++;
        if (want.in_diamond) n_inside++;
      end
      if (res_valid && !res_stall) begin
        n_results++;
        if (mask_q.size() == 0) begin
          report_mismatch("result arrived with no pixel pending");
        end else begin
          want = mask_q.pop_front();
          if (res_inside !== want.in_diamond)
            report_mismatch($sformatf("inside_res %b, want %b (result %0d)",
                                      res_inside, want.in_diamond, n_results));
          if (res_index !== want.lens_index)
            report_mismatch($sformatf("lens_index %0d, want %0d (result %0d)",
                                      res_index, want.lens_index, n_results));
          if (res_offset !== want.source_offset)
            report_mismatch($sformatf("source_offset %0d, want %0d (result %0d)",
                                      res_offset, want.source_offset, n_results));
        end
      end
    end
  end

  // Write one register and mirror it into the predictor's copy
  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_LENS_WIDTH:    lens_w_cur   = data[CoordW-1:0];
      CFG_LENS_HEIGHT:   lens_h_cur   = data[CoordW-1:0];
      CFG_OUTLINE_WIDTH: inset_cur    = data[OwW-1:0];
      CFG_SCREEN_WIDTH:  screen_w_cur = data[ScrW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(logic [CfgW-1:0] w, logic [CfgW-1:0] h,
                              logic [CfgW-1:0] ow, logic [CfgW-1:0] sw);
    write_reg(CFG_LENS_WIDTH, w);
    write_reg(CFG_LENS_HEIGHT, h);
    write_reg(CFG_OUTLINE_WIDTH, ow);
    write_reg(CFG_SCREEN_WIDTH, sw);
    n_settings++;
  endtask

  task automatic queue_pixel(int unsigned x, int unsigned y);
    pixel_t p;
    p.x = x[CoordW-1:0];
    p.y = y[CoordW-1:0];
    pixel_q.push_back(p);
  endtask

  // Wait until every queued pixel is taken and every result is back, then pad
  // with idle clocks before touching the registers again
  task automatic drain_pipeline();
    while (pixel_q.size() != 0 || pix_valid || mask_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Mostly pixels inside the box, with full-range pixels mixed in so every
  // coordinate bit toggles and outside-box pixels keep coming
  task automatic queue_random_pixels(int unsigned count);
    repeat (count) begin
      if ($urandom_range(0, 7) == 0 || lens_w_cur == 0 || lens_h_cur == 0)
        queue_pixel($urandom, $urandom);
      else
        queue_pixel($urandom_range(0, lens_w_cur - 1), $urandom_range(0, lens_h_cur - 1));
    end
  endtask

  initial begin : stimulus
    int unsigned w, h, ow;
    // Hold reset, then release it once
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);

    // Directed, reset geometry 64 x 64, no inset, row of 640: corner (0, 0), two
    // far coordinate corners, centre, all four vertices, a point on the lower-left
    // side and one just off it, a pixel past the box, alternating bit patterns
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(4095, 0);
    queue_pixel(32, 32);
    queue_pixel(0, 32);
    queue_pixel(63, 32);
    queue_pixel(32, 0);
    queue_pixel(32, 63);
    queue_pixel(16, 16);
    queue_pixel(15, 16);
    queue_pixel(64, 32);
    queue_pixel(12'hAAA, 12'h555);
    queue_pixel(12'h555, 12'hAAA);
    drain_pipeline();

    // Smallest box and screen row
    set_geometry(1, 1, 0, 1);
    queue_pixel(0, 0);
    queue_pixel(1, 0);
    queue_pixel(4095, 4095);
    drain_pipeline();

    // Largest box and inset, screen row of 4096; inset written with a spare high bit
    set_geometry(4095, 4095, 13'h1FF, 4096);
    queue_pixel(4095, 4095);
    queue_pixel(2047, 2047);
    queue_pixel(255, 2047);
    drain_pipeline();

    // Inset far beyond half the box: vertices cross over, no clamping
    set_geometry(16, 10, 200, 37);
    queue_pixel(8, 5);
    queue_pixel(0, 0);
    queue_pixel(15, 9);
    drain_pipeline();

    // Zero sizes; width given only by a bit above its field, so it reads as zero
    set_geometry(13'h1000, 0, 0, 0);
    queue_pixel(0, 0);
    queue_pixel(3, 7);
    drain_pipeline();

    // Random geometries, each with a batch of random pixels
    repeat (7) begin
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, 96);
      h = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, 96);
      ow = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                       : $urandom_range(0, ((w < h) ? w : h) / 3);
      set_geometry(CfgW'(w), CfgW'(h), CfgW'(ow), CfgW'($urandom_range(1, 4096)));
      queue_random_pixels(105);
      drain_pipeline();
    end

    $display("Covered %0d pixels (%0d inside the diamond) over %0d geometries plus reset",
             n_pixels, n_inside, n_settings);
    $display("Results checked: %0d, mismatches: %0d", n_results, n_errors);
    if (n_errors == 0) begin
      $display("diamond_mask_rasterizer verification clean");
    end else begin
      $display("diamond_mask_rasterizer verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #400_000;
    $display("Timeout: run did not finish");
    $display("diamond_mask_rasterizer verification failed");
    $finish;
  end

endmodule

`default_nettype wire
